>>> hdl/rbm_pkg.sv
// rbm_pkg: shared widths, divider job codes and controller/datapath structs
// for the row banding measurement block. No dependencies.
package rbm_pkg;

	// Config register width and fixed-point formats
	localparam int REG_W     = 13;
	localparam int FRAC_BITS = 8;
	localparam int AVG_W     = 24;
	localparam int SQ_TERM_W = 2 * AVG_W;
	localparam int OUT_W     = 24;

	// Jobs for the shared divider
	typedef enum logic [1:0] {
		DIV_ROW,
		DIV_MEAN,
		DIV_VAR
	} div_op_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic    pix_add;
		logic    col_inc;
		logic    row_close;
		logic    frame_close;
		logic    row_commit;
		logic    div_start;
		div_op_t div_op;
		logic    avg_latch;
		logic    scan_clr;
		logic    scan_rd;
		logic    sqrt_start;
		logic    frame_clear;
	} rbm_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic row_end_next;
		logic frame_end_next;
		logic div_busy;
		logic div_done;
		logic scan_last;
		logic pipe_busy;
		logic sqrt_done;
	} rbm_stat_t;

endpackage

>>> hdl/rbm_div.sv
// rbm_div: restoring divider, one quotient bit per cycle.
// Dividend is loaded left-aligned; when done is raised the register holds the quotient.
// Depends on nothing.
module rbm_div #(
	parameter int DVD_W = 60,
	parameter int DVS_W = 13,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CNT_W-1:0] steps,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   part;
	logic [DVS_W:0]   diff;
	logic             fits;

	// trial subtract of one shifted-in dividend bit
	assign part = {rem_q, quo_q[DVD_W-1]};
	assign diff = part - {1'b0, dvs_q};
	assign fits = part >= {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift/subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : part[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/rbm_sqrt.sv
// rbm_sqrt: digit-by-digit floor square root, one root bit per cycle.
// Depends on rbm_pkg for the radicand and root widths.
module rbm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rbm_pkg::SQ_TERM_W-1:0] radicand,
	output logic                          done,
	output logic [rbm_pkg::OUT_W-1:0]     root
);

	localparam int RT_W  = rbm_pkg::OUT_W;
	localparam int RAD_W = rbm_pkg::SQ_TERM_W;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [RAD_W-1:0] rad_q;
	logic [RT_W-1:0]  root_q;
	// remainder never exceeds twice the root, so one bit above the root suffices
	logic [RT_W:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RT_W+2:0]  part;
	logic [RT_W+2:0]  trial;
	logic [RT_W+2:0]  diff;
	logic             fits;

	// bring down two radicand bits, try root*4+1
	assign part  = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = part - trial;
	assign fits  = part >= trial;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(RT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// root/remainder update
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[RT_W-2:0], fits};
			rem_q  <= fits ? diff[RT_W:0] : part[RT_W:0];
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hdl/rbm_dpath.sv
// rbm_dpath: row/column counters, accumulators, row-mean store, deviation pipeline,
// shared divider and square-root unit. Depends on rbm_pkg, rbm_div, rbm_sqrt.
module rbm_dpath #(
	parameter int MAX_ROWS    = 4096,
	parameter int MAX_COLUMNS = 4096,
	parameter int PIXEL_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rbm_pkg::rbm_cmd_t         cmd,
	output rbm_pkg::rbm_stat_t        stat,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	input  logic [rbm_pkg::REG_W-1:0] w_eff,
	input  logic [rbm_pkg::REG_W-1:0] h_eff,
	output logic [rbm_pkg::OUT_W-1:0] banding_q8
);

	localparam int AVG_W  = rbm_pkg::AVG_W;
	localparam int TERM_W = rbm_pkg::SQ_TERM_W;
	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int RSUM_W = PIXEL_BITS + $clog2(MAX_COLUMNS);
	localparam int RDVD_W = RSUM_W + rbm_pkg::FRAC_BITS;
	localparam int MSUM_W = AVG_W + $clog2(MAX_ROWS);
	localparam int SSUM_W = TERM_W + $clog2(MAX_ROWS);
	localparam int DIV_W  = (RDVD_W > SSUM_W) ? RDVD_W : SSUM_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	logic [RSUM_W-1:0] row_sum_q;
	logic [RSUM_W-1:0] row_sum_nx;
	logic [COL_W-1:0]  col_q;
	logic [RA_W-1:0]   row_q;
	logic [RA_W-1:0]   row_addr_q;
	logic [ROWS_W-1:0] rows_q;
	logic [MSUM_W-1:0] mean_sum_q;
	logic [AVG_W-1:0]  full_avg_q;
	logic [SSUM_W-1:0] square_sum_q;
	logic [RA_W-1:0]   scan_addr_q;

	logic [AVG_W-1:0]  avg_mem [MAX_ROWS];
	logic [AVG_W-1:0]  rd_data_s1;
	logic              v_s1;
	logic [AVG_W-1:0]  diff_s2;
	logic              v_s2;
	logic [TERM_W-1:0] prod_s3;
	logic              v_s3;

	logic [DIV_W-1:0]          div_dvd;
	logic [DCNT_W-1:0]         div_steps;
	logic [rbm_pkg::REG_W-1:0] div_dvs;
	logic [DIV_W-1:0]          div_quo;
	logic                      div_busy;
	logic                      div_done;
	logic                      sqrt_done;

	assign row_sum_nx = row_sum_q + RSUM_W'(pixel_value);

	// position flags for the pixel on the input now
	assign stat.row_end_next   = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign stat.frame_end_next = (32'(row_q) + 32'd1) >= 32'(h_eff);
	assign stat.div_busy       = div_busy;
	assign stat.div_done       = div_done;
	assign stat.scan_last      = (ROWS_W'(scan_addr_q) + ROWS_W'(1)) == rows_q;
	assign stat.pipe_busy      = v_s1 | v_s2 | v_s3;
	assign stat.sqrt_done      = sqrt_done;

	// row sum and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else begin
			if (cmd.row_close) begin
				row_sum_q <= '0;
				col_q     <= '0;
			end else begin
				if (cmd.pix_add) row_sum_q <= row_sum_nx;
				if (cmd.col_inc) col_q <= col_q + COL_W'(1);
			end
			if (cmd.frame_close) row_q <= '0;
			else if (cmd.row_close) row_q <= row_q + RA_W'(1);
		end
	end

	// row index of the division in flight; row count and mean of the closed frame
	always_ff @(posedge clk) begin
		if (cmd.row_close) row_addr_q <= row_q;
		if (cmd.frame_close) rows_q <= ROWS_W'(32'(row_q) + 32'd1);
		if (cmd.avg_latch) full_avg_q <= div_quo[AVG_W-1:0];
	end

	// sum of row means
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_sum_q <= '0;
		end else if (cmd.frame_clear) begin
			mean_sum_q <= '0;
		end else if (cmd.row_commit) begin
			mean_sum_q <= mean_sum_q + MSUM_W'(div_quo[AVG_W-1:0]);
		end
	end

	// row mean store, registered read
	always_ff @(posedge clk) begin
		if (cmd.row_commit) avg_mem[row_addr_q] <= div_quo[AVG_W-1:0];
		if (cmd.scan_rd) rd_data_s1 <= avg_mem[scan_addr_q];
	end

	// deviation pipeline payload
	always_ff @(posedge clk) begin
		diff_s2 <= (rd_data_s1 >= full_avg_q) ? (rd_data_s1 - full_avg_q)
		                                      : (full_avg_q - rd_data_s1);
		prod_s3 <= diff_s2 * diff_s2;
	end

	// scan address, pipeline valids, squared-deviation sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q  <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			square_sum_q <= '0;
		end else begin
			v_s1 <= cmd.scan_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.scan_clr) begin
				scan_addr_q  <= '0;
				square_sum_q <= '0;
			end else begin
				if (cmd.scan_rd) scan_addr_q <= scan_addr_q + RA_W'(1);
				if (v_s3) square_sum_q <= square_sum_q + SSUM_W'(prod_s3);
			end
		end
	end

	// divider operand select, dividend left-aligned
	always_comb begin
		unique case (cmd.div_op)
			rbm_pkg::DIV_ROW: begin
				div_dvd   = DIV_W'({row_sum_nx, {rbm_pkg::FRAC_BITS{1'b0}}}) << (DIV_W - RDVD_W);
				div_steps = DCNT_W'(RDVD_W);
				div_dvs   = w_eff;
			end
			rbm_pkg::DIV_MEAN: begin
				div_dvd   = DIV_W'(mean_sum_q) << (DIV_W - MSUM_W);
				div_steps = DCNT_W'(MSUM_W);
				div_dvs   = rbm_pkg::REG_W'(rows_q);
			end
			rbm_pkg::DIV_VAR: begin
				div_dvd   = DIV_W'(square_sum_q) << (DIV_W - SSUM_W);
				div_steps = DCNT_W'(SSUM_W);
				div_dvs   = rbm_pkg::REG_W'(rows_q);
			end
			default: begin
				div_dvd   = '0;
				div_steps = DCNT_W'(1);
				div_dvs   = rbm_pkg::REG_W'(1);
			end
		endcase
	end

	rbm_div #(
		.DVD_W (DIV_W),
		.DVS_W (rbm_pkg::REG_W),
		.CNT_W (DCNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.steps    (div_steps),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	rbm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (div_quo[TERM_W-1:0]),
		.done     (sqrt_done),
		.root     (banding_q8)
	);

	// scan never reads past the rows of the closed frame
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (ROWS_W'(scan_addr_q) < rows_q))
		else $error("row store scan beyond frame rows");

endmodule

>>> hdl/rbm_ctrl.sv
// rbm_ctrl: sequencer for pixel intake, row-mean commits and the frame-end pass.
// Drives rbm_cmd_t, reads rbm_stat_t. Depends on rbm_pkg.
module rbm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output rbm_pkg::rbm_cmd_t  cmd,
	input  rbm_pkg::rbm_stat_t stat
);

	localparam logic [3:0] ST_RUN     = 4'd0;
	localparam logic [3:0] ST_ROWWAIT = 4'd1;
	localparam logic [3:0] ST_MEANST  = 4'd2;
	localparam logic [3:0] ST_MEANDIV = 4'd3;
	localparam logic [3:0] ST_SCAN    = 4'd4;
	localparam logic [3:0] ST_DRAIN   = 4'd5;
	localparam logic [3:0] ST_VARST   = 4'd6;
	localparam logic [3:0] ST_VARDIV  = 4'd7;
	localparam logic [3:0] ST_SQRT    = 4'd8;
	localparam logic [3:0] ST_OUT     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       take;

	// a row-end pixel waits for the divider to free up
	assign busy = (state_q != ST_RUN) || (stat.div_busy && stat.row_end_next);
	assign take = start && !busy;
	assign done = (state_q == ST_OUT);

	always_comb begin
		cmd        = '0;
		cmd.div_op = rbm_pkg::DIV_ROW;
		state_nx   = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (stat.div_done) cmd.row_commit = 1'b1;
				if (take) begin
					cmd.pix_add = 1'b1;
					if (stat.row_end_next) begin
						cmd.row_close = 1'b1;
						cmd.div_start = 1'b1;
						if (stat.frame_end_next) begin
							cmd.frame_close = 1'b1;
							state_nx        = ST_ROWWAIT;
						end
					end else begin
						cmd.col_inc = 1'b1;
					end
				end
			end
			ST_ROWWAIT: begin
				if (stat.div_done) begin
					cmd.row_commit = 1'b1;
					state_nx       = ST_MEANST;
				end
			end
			ST_MEANST: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = rbm_pkg::DIV_MEAN;
				state_nx      = ST_MEANDIV;
			end
			ST_MEANDIV: begin
				if (stat.div_done) begin
					cmd.avg_latch = 1'b1;
					cmd.scan_clr  = 1'b1;
					state_nx      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_nx = ST_VARST;
			end
			ST_VARST: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = rbm_pkg::DIV_VAR;
				state_nx      = ST_VARDIV;
			end
			ST_VARDIV: begin
				if (stat.div_done) begin
					cmd.sqrt_start = 1'b1;
					state_nx       = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (stat.sqrt_done) state_nx = ST_OUT;
			end
			ST_OUT: begin
				cmd.frame_clear = 1'b1;
				state_nx        = ST_RUN;
			end
			default: begin
				state_nx = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_nx;
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	a_sqrt_seq: assert property (@(posedge clk) disable iff (!arst_n)
		stat.sqrt_done |-> (state_q == ST_SQRT))
		else $error("square root finished outside its phase");

endmodule

>>> hdl/row_banding_measure_top.sv
// row_banding_measure_top: APB config registers, register clamping, controller and datapath.
// Depends on rbm_pkg, rbm_ctrl, rbm_dpath.
//
// Usage: pixels arrive in raster order on pixel_value; a request is taken at a clock
// edge where start is high and busy is low. image_width (addr 0) and image_height
// (addr 4) set the frame shape; 0 acts as 1, values above the maxima saturate.
// Throughput: one pixel per cycle. Each row end starts a restoring division of the
// row sum that runs while the next row streams in; a row-end pixel is held off with
// busy until that divider is free, so short rows are paced by the row division.
// After the frame's last pixel busy stays high through the last row division, the
// frame mean division, the store scan and drain, the variance division, the square
// root and the done cycle. done pulses in that last cycle with banding_q8 and the
// accumulators clear for the next frame. The receiver cannot stall: the result is
// valid only in the done cycle.
// Reset clears counters and sums and sets both registers to 4096; the row mean
// store holds no reset value and is only read at rows written in the current frame.
module row_banding_measure_top #(
	parameter int MAX_ROWS    = 4096,
	parameter int MAX_COLUMNS = 4096,
	parameter int PIXEL_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	output logic                      done,
	output logic [rbm_pkg::OUT_W-1:0] banding_q8
);

	localparam int         REG_W      = rbm_pkg::REG_W;
	localparam logic       IDX_WIDTH  = 1'b0;
	localparam logic       IDX_HEIGHT = 1'b1;
	localparam logic [REG_W-1:0] REG_RESET = REG_W'(4096);

	logic [REG_W-1:0] width_q;
	logic [REG_W-1:0] height_q;
	logic [REG_W-1:0] w_eff;
	logic [REG_W-1:0] h_eff;
	logic             wr_en;

	rbm_pkg::rbm_cmd_t  cmd;
	rbm_pkg::rbm_stat_t stat;

	// APB register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= REG_RESET;
			height_q <= REG_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				IDX_WIDTH:  width_q  <= pwdata[REG_W-1:0];
				IDX_HEIGHT: height_q <= pwdata[REG_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == IDX_HEIGHT) ? 32'(height_q) : 32'(width_q);

	// zero acts as one, oversize saturates
	always_comb begin
		if (width_q == '0) w_eff = REG_W'(1);
		else if (32'(width_q) > MAX_COLUMNS) w_eff = REG_W'(MAX_COLUMNS);
		else w_eff = width_q;

		if (height_q == '0) h_eff = REG_W'(1);
		else if (32'(height_q) > MAX_ROWS) h_eff = REG_W'(MAX_ROWS);
		else h_eff = height_q;
	end

	rbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	rbm_dpath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS),
		.PIXEL_BITS  (PIXEL_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.pixel_value (pixel_value),
		.w_eff       (w_eff),
		.h_eff       (h_eff),
		.banding_q8  (banding_q8)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for row_banding_measure_top. Streams raster frames of
// pixels, predicts the banding value of each frame and checks every done strobe.
// Depends on rbm_pkg and row_banding_measure_top.
module tb_top;

	localparam int          PIX_W        = 16;
	localparam int unsigned ROWS_MAX     = 4096;
	localparam int unsigned COLS_MAX     = 4096;
	localparam int          RANDOM_ITEMS = 1700;
	localparam int          CYCLE_LIMIT  = 3000000;

	// Register byte addresses
	localparam logic [2:0] REG_WIDTH_ADDR  = 3'd0;
	localparam logic [2:0] REG_HEIGHT_ADDR = 3'd4;

	// Pixel content styles for generated frames
	typedef enum int {
		PAT_RANDOM,
		PAT_EXTREME,
		PAT_ROW_LEVEL,
		PAT_FLAT,
		PAT_NOISE
	} pattern_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      psel        = 1'b0;
	logic                      penable     = 1'b0;
	logic                      pwrite      = 1'b0;
	logic [2:0]                paddr       = '0;
	logic [31:0]               pwdata      = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      start       = 1'b0;
	logic                      busy;
	logic [PIX_W-1:0]          pixel_value = '0;
	logic                      done;
	logic [rbm_pkg::OUT_W-1:0] banding_q8;

	// Stimulus and scoreboard storage
	logic [PIX_W-1:0]          pixel_pending_q[$];
	logic [rbm_pkg::OUT_W-1:0] banding_expected_q[$];
	int                        send_idle_pct = 31;
	int                        err_count     = 0;
	int                        queued_items  = 0;
	int                        cycle_cnt     = 0;

	// Predictor state: register shadows, accumulators, row mean store
	logic [rbm_pkg::REG_W-1:0] cfg_width  = 13'd4096;
	logic [rbm_pkg::REG_W-1:0] cfg_height = 13'd4096;
	logic [63:0]               row_acc    = '0;
	logic [63:0]               mean_acc   = '0;
	int unsigned               col_idx    = 0;
	int unsigned               row_idx    = 0;
	logic [rbm_pkg::AVG_W-1:0] row_mean_mem [ROWS_MAX];

	row_banding_measure_top #(
		.MAX_ROWS    (ROWS_MAX),
		.MAX_COLUMNS (COLS_MAX),
		.PIXEL_BITS  (PIX_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.pixel_value (pixel_value),
		.done        (done),
		.banding_q8  (banding_q8)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	// Register value as the block uses it: zero acts as one, large values saturate
	function automatic int unsigned dim_eff(input logic [rbm_pkg::REG_W-1:0] v,
	                                        input int unsigned top);
		if (v == 0) begin
			return 1;
		end else if (v > top) begin
			return top;
		end
		return v;
	endfunction

	// Floor square root, one result bit per step from the top
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) begin
				root = trial;
			end
		end
		return root;
	endfunction

	// Advance the frame accumulators by one accepted pixel; queue the banding
	// value when the pixel closes the frame
	task automatic predict_pixel(input logic [PIX_W-1:0] pix);
		int unsigned w;
		int unsigned h;
		int unsigned rows;
		logic [63:0] avg;
		logic [63:0] frame_mean;
		logic [63:0] dev;
		logic [63:0] sq_acc;
		logic [63:0] root;
		w = dim_eff(cfg_width, COLS_MAX);
		h = dim_eff(cfg_height, ROWS_MAX);
		row_acc += pix;
		if (col_idx + 1 < w) begin
			col_idx++;
		end else begin
			// row end: Q16.8 mean, truncated to the store width
			avg = ((row_acc << 8) / w) & 64'hFF_FFFF;
			row_mean_mem[row_idx] = avg[rbm_pkg::AVG_W-1:0];
			mean_acc += avg;
			row_acc = '0;
			col_idx = 0;
			if (row_idx + 1 < h) begin
				row_idx++;
			end else begin
				// frame end: spread of the row means around their mean
				rows = row_idx + 1;
				frame_mean = mean_acc / rows;
				sq_acc = '0;
				for (int r = 0; r < rows; r++) begin
					if (row_mean_mem[r] >= frame_mean) begin
						dev = row_mean_mem[r] - frame_mean;
					end else begin
						dev = frame_mean - row_mean_mem[r];
					end
					sq_acc += dev * dev;
				end
				root = int_sqrt(sq_acc / rows);
				banding_expected_q.push_back(root[rbm_pkg::OUT_W-1:0]);
				mean_acc = '0;
				row_idx = 0;
			end
		end
	endtask

	// Request driver: holds a request until taken, random gaps between requests
	always @(posedge clk) begin : pixel_driver
		logic feed_next;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			feed_next = !start || !busy;
			if (start && !busy) begin
				predict_pixel(pixel_value);
				void'(pixel_pending_q.pop_front());
			end
			if (feed_next) begin
				if (pixel_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					start       <= 1'b1;
					pixel_value <= pixel_pending_q[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: each done strobe against the oldest expectation
	always @(posedge clk) begin : result_monitor
		logic [rbm_pkg::OUT_W-1:0] want;
		if (arst_n && done) begin
			if (banding_expected_q.size() == 0) begin
				note_error($sformatf("unexpected result banding_q8=%0h", banding_q8));
			end else begin
				want = banding_expected_q.pop_front();
				if (banding_q8 !== want) begin
					note_error($sformatf("banding_q8 expected %0h got %0h", want, banding_q8));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Wait until every request is taken and every result is in, then pad
	task automatic wait_idle(input int pad);
		while (pixel_pending_q.size() != 0 || start) @(posedge clk);
		while (banding_expected_q.size() != 0) @(posedge clk);
		repeat (pad) @(posedge clk);
	endtask

	// APB write: setup then access; upper data bits are junk the block ignores
	task automatic write_reg(input logic [2:0] addr, input int value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {19'($urandom), 13'(value)};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_WIDTH_ADDR) begin
			cfg_width = 13'(value);
		end else begin
			cfg_height = 13'(value);
		end
	endtask

	task automatic set_shape(input int w, input int h);
		wait_idle(4);
		write_reg(REG_WIDTH_ADDR, w);
		write_reg(REG_HEIGHT_ADDR, h);
	endtask

	// Queue one whole frame at the current shape
	task automatic queue_frame(input pattern_t pat);
		int unsigned      w;
		int unsigned      h;
		int               val;
		logic [PIX_W-1:0] base;
		logic [PIX_W-1:0] level;
		w = dim_eff(cfg_width, COLS_MAX);
		h = dim_eff(cfg_height, ROWS_MAX);
		base = PIX_W'($urandom_range(65535));
		for (int unsigned r = 0; r < h; r++) begin
			if ($urandom_range(3) == 0) begin
				level = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			end else begin
				level = PIX_W'($urandom_range(65535));
			end
			for (int unsigned c = 0; c < w; c++) begin
				case (pat)
					PAT_RANDOM:    val = $urandom_range(65535);
					PAT_EXTREME:   val = $urandom_range(1) ? 65535 : 0;
					PAT_ROW_LEVEL: val = level;
					PAT_FLAT:      val = base;
					default: begin
						val = int'(base) + int'($urandom_range(16)) - 8;
						val = (val < 0) ? 0 : (val > 65535) ? 65535 : val;
					end
				endcase
				pixel_pending_q.push_back(PIX_W'(val));
			end
		end
		queued_items += w * h;
	endtask

	// Main sequence
	initial begin
		logic [PIX_W-1:0] grid3 [9];
		int               target;
		int               sel;
		int               w;
		int               h;
		grid3 = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			16'h0001, 16'h0002, 16'h0003};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single pixel frame, full scale
		set_shape(1, 1);
		pixel_pending_q.push_back(16'hFFFF);
		// zero registers act as one
		set_shape(0, 0);
		pixel_pending_q.push_back(16'h0000);
		// two rows at opposite extremes: largest spread
		set_shape(2, 2);
		pixel_pending_q.push_back(16'h0000);
		pixel_pending_q.push_back(16'h0000);
		pixel_pending_q.push_back(16'hFFFF);
		pixel_pending_q.push_back(16'hFFFF);
		// mixed 3x3
		set_shape(3, 3);
		foreach (grid3[k]) pixel_pending_q.push_back(grid3[k]);
		// shape shrunk in the middle of a row: row and frame close early
		set_shape(5, 4);
		repeat (7) pixel_pending_q.push_back(PIX_W'($urandom_range(1000)));
		wait_idle(300);
		write_reg(REG_WIDTH_ADDR, 2);
		write_reg(REG_HEIGHT_ADDR, 2);
		pixel_pending_q.push_back(PIX_W'($urandom_range(1000)));

		// random frames in three idle phases
		queued_items = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 75 : 0;
			target = queued_items + RANDOM_ITEMS / 3;
			while (queued_items < target) begin
				sel = $urandom_range(99);
				w = (sel < 5) ? 0 : (sel < 75) ? $urandom_range(8, 1) :
					(sel < 95) ? $urandom_range(40, 9) : $urandom_range(100, 41);
				sel = $urandom_range(99);
				h = (sel < 5) ? 0 : (sel < 80) ? $urandom_range(6, 1) : $urandom_range(24, 7);
				set_shape(w, h);
				repeat ($urandom_range(3, 1)) queue_frame(pattern_t'($urandom_range(PAT_NOISE)));
			end
		end

		// oversize registers saturate; a long partial row then closes on a shrink,
		// and its mean wraps at the store width
		send_idle_pct = 0;
		set_shape(8191, 8191);
		repeat (60) pixel_pending_q.push_back(PIX_W'($urandom_range(65535)));
		wait_idle(40);
		write_reg(REG_WIDTH_ADDR, 3);
		write_reg(REG_HEIGHT_ADDR, 2);
		repeat (4) pixel_pending_q.push_back(PIX_W'($urandom_range(65535)));

		wait_idle(300);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/rbm_pkg.sv
hdl/rbm_div.sv
hdl/rbm_sqrt.sv
hdl/rbm_dpath.sv
hdl/rbm_ctrl.sv
hdl/row_banding_measure_top.sv
tb/tb_top.sv
